// ===== design/e2cal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_pkg
// Shared widths, constants, control structs and the month length table for
// the epoch day count to calendar date converter.
// ----------------------------------------------------------------------------
package e2cal_pkg;

    localparam int DAY_COUNT_BITS  = 20;
    localparam int SECS_BITS       = 37;
    localparam int MICRO_BITS      = 20;
    localparam int YEAR_BITS       = 13;
    localparam int MONTH_BITS      = 4;
    localparam int MDAY_BITS       = 5;
    localparam int HOUR_BITS       = 5;
    localparam int MINUTE_BITS     = 6;
    localparam int SECOND_BITS     = 6;
    localparam int RESID_BITS      = 17;
    localparam int DSEC_BITS       = DAY_COUNT_BITS + RESID_BITS;
    localparam int WIDE_BITS       = (DSEC_BITS > SECS_BITS) ? DSEC_BITS : SECS_BITS;

    localparam int EPOCH_YEAR      = 1970;
    localparam int EPOCH_MOD100    = EPOCH_YEAR % 100;
    localparam int EPOCH_MOD400    = EPOCH_YEAR % 400;
    localparam int DAYS_PER_CYCLE  = 146097;
    localparam int YEARS_PER_CYCLE = 400;
    localparam int SECONDS_PER_DAY = 86400;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MINUTE = 60;
    localparam int LAST_MONTH      = 11;

    typedef struct packed {
        logic load;
        logic cyc_step;
        logic year_step;
        logic month_step;
        logic resid_load;
        logic hour_step;
        logic minute_step;
    } cmd_t;

    typedef struct packed {
        logic cyc_more;
        logic year_more;
        logic month_more;
        logic hour_more;
        logic minute_more;
    } status_t;

    typedef struct packed {
        logic [YEAR_BITS-1:0]   year_value;
        logic [MONTH_BITS-1:0]  month_index;
        logic [MDAY_BITS-1:0]   day_of_month;
        logic [HOUR_BITS-1:0]   hour_value;
        logic [MINUTE_BITS-1:0] minute_value;
        logic [SECOND_BITS-1:0] second_value;
        logic [MICRO_BITS-1:0]  micro_out;
        logic                   time_error;
    } result_t;

    function automatic logic [MDAY_BITS-1:0] month_days(
        input logic [MONTH_BITS-1:0] month,
        input logic                  leap
    );
        logic [MDAY_BITS-1:0] len;
        case (month)
            4'd1:                         len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
            default:                      len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== design/e2cal_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_dpath
// Datapath: 400-year cycle, year and month stepping on the remaining day
// count, residual seconds and hour / minute stepping by subtraction.
// ----------------------------------------------------------------------------
module e2cal_dpath (
    input  logic                                   clk,
    input  logic [e2cal_pkg::DAY_COUNT_BITS-1:0]   day_count,
    input  logic [e2cal_pkg::SECS_BITS-1:0]        epoch_seconds,
    input  logic [e2cal_pkg::MICRO_BITS-1:0]       micro_seconds,
    input  e2cal_pkg::cmd_t                        cmd,
    output e2cal_pkg::status_t                     status,
    output e2cal_pkg::result_t                     result
);

    logic [e2cal_pkg::DAY_COUNT_BITS-1:0] rem_reg,    rem_next;
    logic [e2cal_pkg::YEAR_BITS-1:0]      year_reg,   year_next;
    logic [6:0]                           mod100_reg, mod100_next;
    logic [8:0]                           mod400_reg, mod400_next;
    logic [e2cal_pkg::MONTH_BITS-1:0]     month_reg,  month_next;
    logic [e2cal_pkg::SECS_BITS-1:0]      secs_reg,   secs_next;
    logic [e2cal_pkg::DSEC_BITS-1:0]      dsec_reg,   dsec_next;
    logic [e2cal_pkg::MICRO_BITS-1:0]     micro_reg,  micro_next;
    logic [e2cal_pkg::RESID_BITS-1:0]     resid_reg,  resid_next;
    logic [e2cal_pkg::HOUR_BITS-1:0]      hour_reg,   hour_next;
    logic [e2cal_pkg::MINUTE_BITS-1:0]    minute_reg, minute_next;
    logic                                 err_reg,    err_next;

    logic                                 leap;
    logic [8:0]                           year_len;
    logic [e2cal_pkg::MDAY_BITS-1:0]      month_len;
    logic [e2cal_pkg::WIDE_BITS-1:0]      secs_wide;
    logic [e2cal_pkg::WIDE_BITS-1:0]      dsec_wide;
    logic [e2cal_pkg::WIDE_BITS-1:0]      diff;
    logic                                 resid_bad;

    always_comb
    begin
        leap      = (year_reg[1:0] == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
        year_len  = leap ? 9'd366 : 9'd365;
        month_len = e2cal_pkg::month_days(month_reg, leap);

        status.cyc_more    = 32'(rem_reg) >= 32'(e2cal_pkg::DAYS_PER_CYCLE);
        status.year_more   = 32'(rem_reg) >= 32'(year_len);
        status.month_more  = (month_reg < e2cal_pkg::MONTH_BITS'(e2cal_pkg::LAST_MONTH))
                          && (32'(rem_reg) >= 32'(month_len));
        status.hour_more   = resid_reg >= e2cal_pkg::RESID_BITS'(e2cal_pkg::SECS_PER_HOUR);
        status.minute_more = resid_reg >= e2cal_pkg::RESID_BITS'(e2cal_pkg::SECS_PER_MINUTE);

        secs_wide = e2cal_pkg::WIDE_BITS'(secs_reg);
        dsec_wide = e2cal_pkg::WIDE_BITS'(dsec_reg);
        diff      = secs_wide - dsec_wide;
        resid_bad = (secs_wide < dsec_wide)
                 || (diff >= e2cal_pkg::WIDE_BITS'(e2cal_pkg::SECONDS_PER_DAY));
    end

    always_comb
    begin
        rem_next    = rem_reg;
        year_next   = year_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        month_next  = month_reg;
        secs_next   = secs_reg;
        dsec_next   = dsec_reg;
        micro_next  = micro_reg;
        resid_next  = resid_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        err_next    = err_reg;

        if (cmd.load)
        begin
            rem_next    = day_count;
            year_next   = e2cal_pkg::YEAR_BITS'(e2cal_pkg::EPOCH_YEAR);
            mod100_next = 7'(e2cal_pkg::EPOCH_MOD100);
            mod400_next = 9'(e2cal_pkg::EPOCH_MOD400);
            month_next  = '0;
            secs_next   = epoch_seconds;
            dsec_next   = e2cal_pkg::DSEC_BITS'(day_count)
                        * e2cal_pkg::DSEC_BITS'(e2cal_pkg::SECONDS_PER_DAY);
            micro_next  = micro_seconds;
            hour_next   = '0;
            minute_next = '0;
        end
        if (cmd.cyc_step)
        begin
            rem_next  = rem_reg - e2cal_pkg::DAY_COUNT_BITS'(e2cal_pkg::DAYS_PER_CYCLE);
            year_next = year_reg + e2cal_pkg::YEAR_BITS'(e2cal_pkg::YEARS_PER_CYCLE);
        end
        if (cmd.year_step)
        begin
            rem_next    = rem_reg - e2cal_pkg::DAY_COUNT_BITS'(year_len);
            year_next   = year_reg + 1'b1;
            mod100_next = (mod100_reg == 7'd99)  ? 7'd0 : mod100_reg + 7'd1;
            mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
        end
        if (cmd.month_step)
        begin
            rem_next   = rem_reg - e2cal_pkg::DAY_COUNT_BITS'(month_len);
            month_next = month_reg + 1'b1;
        end
        if (cmd.resid_load)
        begin
            err_next   = resid_bad;
            resid_next = resid_bad ? '0 : diff[e2cal_pkg::RESID_BITS-1:0];
        end
        if (cmd.hour_step)
        begin
            resid_next = resid_reg - e2cal_pkg::RESID_BITS'(e2cal_pkg::SECS_PER_HOUR);
            hour_next  = hour_reg + 1'b1;
        end
        if (cmd.minute_step)
        begin
            resid_next  = resid_reg - e2cal_pkg::RESID_BITS'(e2cal_pkg::SECS_PER_MINUTE);
            minute_next = minute_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        year_reg   <= year_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg  <= month_next;
        secs_reg   <= secs_next;
        dsec_reg   <= dsec_next;
        micro_reg  <= micro_next;
        resid_reg  <= resid_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        err_reg    <= err_next;
    end

    always_comb
    begin
        result.year_value   = year_reg;
        result.month_index  = month_reg;
        result.day_of_month = rem_reg[e2cal_pkg::MDAY_BITS-1:0] + 1'b1;
        result.hour_value   = hour_reg;
        result.minute_value = minute_reg;
        result.second_value = resid_reg[e2cal_pkg::SECOND_BITS-1:0];
        result.micro_out    = micro_reg;
        result.time_error   = err_reg;
    end

endmodule

// ===== design/e2cal_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_ctrl
// Controller: sequences load, cycle, year, month, residual, hour and minute
// steps, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module e2cal_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  e2cal_pkg::status_t status,
    input  logic               out_free,
    output e2cal_pkg::cmd_t    cmd,
    output logic               out_load
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CYCLE,
        S_YEAR,
        S_MONTH,
        S_RESID,
        S_HOUR,
        S_MINUTE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CYCLE;
                end
            end
            S_CYCLE:
            begin
                if (status.cyc_more) cmd.cyc_step = 1'b1;
                else                 state_next   = S_YEAR;
            end
            S_YEAR:
            begin
                if (status.year_more) cmd.year_step = 1'b1;
                else                  state_next    = S_MONTH;
            end
            S_MONTH:
            begin
                if (status.month_more) cmd.month_step = 1'b1;
                else                   state_next     = S_RESID;
            end
            S_RESID:
            begin
                cmd.resid_load = 1'b1;
                state_next     = S_HOUR;
            end
            S_HOUR:
            begin
                if (status.hour_more) cmd.hour_step = 1'b1;
                else                  state_next    = S_MINUTE;
            end
            S_MINUTE:
            begin
                if (status.minute_more) cmd.minute_step = 1'b1;
                else                    state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/e2cal_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_out
// Output register: holds one finished item until the consumer takes it.
// ----------------------------------------------------------------------------
module e2cal_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  e2cal_pkg::result_t result_in,
    output logic               free,
    output logic               result_valid,
    input  logic               result_ready,
    output e2cal_pkg::result_t result_out
);

    logic               valid_reg, valid_next;
    e2cal_pkg::result_t data_reg,  data_next;

    always_comb
    begin
        free       = !valid_reg || result_ready;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = result_in;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign result_out   = data_reg;

endmodule

// ===== design/epoch_days_to_calendar_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_days_to_calendar_date
// Converts a day count since 1970-01-01 and epoch seconds into Gregorian
// year, month, day of month and hour, minute, second, with a range flag.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------
//   input   | item_valid / item_ready    | day_count, epoch_seconds,
//           |                            | micro_seconds
//   output  | result_valid / result_ready| year_value, month_index,
//           |                            | day_of_month, hour_value,
//           |                            | minute_value, second_value,
//           |                            | micro_out, time_error
//
// one item at a time: after accept, the controller steps 400-year cycles,
// then years, then months, loads the residual seconds, then steps hours
// and minutes before handing the result to the output register
// every step is one subtract in the shared datapath, one per cycle
// item_ready is high only while the controller is idle; a finished result
// sits in the output register, so the next item is taken while it waits
// reset clears the controller and the output valid flag only
// ----------------------------------------------------------------------------
module epoch_days_to_calendar_date (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic [e2cal_pkg::DAY_COUNT_BITS-1:0]  day_count,
    input  logic [e2cal_pkg::SECS_BITS-1:0]       epoch_seconds,
    input  logic [e2cal_pkg::MICRO_BITS-1:0]      micro_seconds,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [e2cal_pkg::YEAR_BITS-1:0]       year_value,
    output logic [e2cal_pkg::MONTH_BITS-1:0]      month_index,
    output logic [e2cal_pkg::MDAY_BITS-1:0]       day_of_month,
    output logic [e2cal_pkg::HOUR_BITS-1:0]       hour_value,
    output logic [e2cal_pkg::MINUTE_BITS-1:0]     minute_value,
    output logic [e2cal_pkg::SECOND_BITS-1:0]     second_value,
    output logic [e2cal_pkg::MICRO_BITS-1:0]      micro_out,
    output logic                                  time_error
);

    e2cal_pkg::cmd_t    cmd;
    e2cal_pkg::status_t status;
    e2cal_pkg::result_t dp_result;
    e2cal_pkg::result_t out_result;
    logic               out_free;
    logic               out_load;

    e2cal_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .out_free   (out_free),
        .cmd        (cmd),
        .out_load   (out_load)
    );

    e2cal_dpath u_dpath (
        .clk           (clk),
        .day_count     (day_count),
        .epoch_seconds (epoch_seconds),
        .micro_seconds (micro_seconds),
        .cmd           (cmd),
        .status        (status),
        .result        (dp_result)
    );

    e2cal_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .result_in    (dp_result),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_out   (out_result)
    );

    assign year_value   = out_result.year_value;
    assign month_index  = out_result.month_index;
    assign day_of_month = out_result.day_of_month;
    assign hour_value   = out_result.hour_value;
    assign minute_value = out_result.minute_value;
    assign second_value = out_result.second_value;
    assign micro_out    = out_result.micro_out;
    assign time_error   = out_result.time_error;

endmodule
